// ===== sv/cbc_pkg.sv =====
`timescale 1ns / 1ps
package cbc_pkg;

    localparam int TAG_W    = 16;
    localparam int RADIUS_W = 23;
    localparam int ARENA_W  = 22;
    localparam int COEF_W   = 17;
    localparam int VAL_W    = 32;
    localparam int ADDR_W   = 2;

    localparam logic [ARENA_W-1:0] ARENA_MIN   = 22'd131072;
    localparam logic [ARENA_W-1:0] ARENA_MAX   = 22'd2621440;
    localparam logic [ARENA_W-1:0] ARENA_RST   = 22'd655360;
    localparam logic [ARENA_W-1:0] MIN_ALLOWED = 22'd655;
    localparam logic [COEF_W-1:0]  UNIT_Q16    = 17'd65536;
    localparam logic [COEF_W-1:0]  REST_RST    = 17'd47186;
    localparam logic [COEF_W-1:0]  DAMP_RST    = 17'd62915;

    localparam int QUEUE_DEPTH = 4;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 17;

    typedef enum logic [ADDR_W-1:0] {
        REG_ARENA = 2'd0,
        REG_REST  = 2'd1,
        REG_DAMP  = 2'd2
    } cfg_reg_t;

    // one body as it travels from the front to the back
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic                last;
        logic                hit;
        logic [ARENA_W-1:0]  allowed;
        logic [63:0]         dsq;
        logic signed [31:0]  px;
        logic signed [31:0]  py;
        logic signed [31:0]  pz;
        logic signed [31:0]  vx;
        logic signed [31:0]  vy;
        logic signed [31:0]  vz;
    } item_t;

    // round(a * b / 65536), halves away from zero
    function automatic logic signed [38:0] mul_q16(input logic signed [35:0] a,
                                                  input logic signed [17:0] b);
        logic [35:0] ma;
        logic [17:0] mb;
        logic [53:0] p;
        logic [37:0] q;
        ma = a[35] ? 36'(-a) : 36'(a);
        mb = b[17] ? 18'(-b) : 18'(b);
        p  = 54'(ma) * 54'(mb);
        q  = 38'((p + 54'd32768) >> 16);
        mul_q16 = (a[35] != b[17]) ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // saturate to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            sat32 = 32'h7FFF_FFFF;
        else if (v < -40'sd2147483648)
            sat32 = 32'h8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// ===== sv/circular_boundary_collision.sv =====
`timescale 1ns / 1ps
// Circular arena boundary for sphere bodies, one body per request.
// Input side is a queue: drive the body fields with push; the body is taken
// at a clock edge where push is high and full is low. Result side is a queue
// too: while empty is low the oldest result sits on the out ports and is
// taken at an edge where pop is high. Exactly one result per body, in order.
// Config: cfg_addr 0 arena radius, 1 restitution, 2 tangent damping, written
// when cfg_valid is high (cfg_ready is always high); values are clamped into
// range on write. Write only while no body is in flight.
// From the accepting edge to the result register a body passes 57 register
// stages, the first loaded at the accepting edge: 2 front stages, the
// classify queue, a 32-stage square root, a 17-stage divider for the normal,
// 4 multiply stages and the result register. Throughput is one body per
// cycle while pop keeps the result side moving; the square root and divider
// are fully pipelined.
// If pop stays low the back pipeline freezes, the 4-entry queue fills, then
// the front freezes and full goes high. Reset empties every stage and loads
// arena 10.0, restitution 0.72 and damping 0.96.
module circular_boundary_collision #(
    parameter int QUEUE_DEPTH = cbc_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [cbc_pkg::TAG_W-1:0]     body_tag,
    input  logic                          body_active,
    input  logic [cbc_pkg::RADIUS_W-1:0]  body_radius,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic signed [31:0]            vel_x,
    input  logic signed [31:0]            vel_y,
    input  logic signed [31:0]            vel_z,
    input  logic                          last_body,
    output logic                          empty,
    input  logic                          pop,
    output logic [cbc_pkg::TAG_W-1:0]     out_tag,
    output logic                          clamped,
    output logic signed [31:0]            new_pos_x,
    output logic signed [31:0]            new_pos_y,
    output logic signed [31:0]            new_pos_z,
    output logic signed [31:0]            new_vel_x,
    output logic signed [31:0]            new_vel_y,
    output logic signed [31:0]            new_vel_z,
    output logic                          out_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbc_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [cbc_pkg::ARENA_W-1:0]   cfg_data
);
    import cbc_pkg::*;

    logic [ARENA_W-1:0] arena_reg;
    logic [COEF_W-1:0]  rest_reg;
    logic [COEF_W-1:0]  damp_reg;
    logic [COEF_W-1:0]  coef_in;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    item_t              q_in_item;
    item_t              q_out_item;

    assign cfg_ready = 1'b1;
    assign coef_in   = (cfg_data[COEF_W-1:0] > UNIT_Q16) ? UNIT_Q16 : cfg_data[COEF_W-1:0];

    // hold the clamped register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg <= ARENA_RST;
            rest_reg  <= REST_RST;
            damp_reg  <= DAMP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_ARENA:
                begin
                    if (cfg_data < ARENA_MIN)
                        arena_reg <= ARENA_MIN;
                    else if (cfg_data > ARENA_MAX)
                        arena_reg <= ARENA_MAX;
                    else
                        arena_reg <= cfg_data;
                end
                REG_REST: rest_reg <= coef_in;
                REG_DAMP: damp_reg <= coef_in;
                default:  ;
            endcase
        end
    end

    cbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .body_tag    (body_tag),
        .body_active (body_active),
        .body_radius (body_radius),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .vel_z       (vel_z),
        .last_body   (last_body),
        .arena       (arena_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_in_item)
    );

    cbc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .in_item  (q_in_item),
        .full     (q_full),
        .pop      (q_pop),
        .out_item (q_out_item),
        .empty    (q_empty)
    );

    cbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .rest      (rest_reg),
        .damp      (damp_reg),
        .pop       (pop),
        .empty     (empty),
        .out_tag   (out_tag),
        .clamped   (clamped),
        .new_pos_x (new_pos_x),
        .new_pos_y (new_pos_y),
        .new_pos_z (new_pos_z),
        .new_vel_x (new_vel_x),
        .new_vel_y (new_vel_y),
        .new_vel_z (new_vel_z),
        .out_last  (out_last)
    );

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_arena_range: assert property (@(posedge clk) disable iff (!rst_n)
        (arena_reg >= ARENA_MIN) && (arena_reg <= ARENA_MAX))
        else $error("arena radius out of range");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rest_reg <= UNIT_Q16) && (damp_reg <= UNIT_Q16))
        else $error("coefficient above one");

endmodule

// ===== sv/cbc_front.sv =====
`timescale 1ns / 1ps
module cbc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [cbc_pkg::TAG_W-1:0]     body_tag,
    input  logic                          body_active,
    input  logic [cbc_pkg::RADIUS_W-1:0]  body_radius,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic signed [31:0]            vel_x,
    input  logic signed [31:0]            vel_y,
    input  logic signed [31:0]            vel_z,
    input  logic                          last_body,
    input  logic [cbc_pkg::ARENA_W-1:0]   arena,
    input  logic                          q_full,
    output logic                          q_push,
    output cbc_pkg::item_t                q_item
);
    import cbc_pkg::*;

    logic               en;
    logic               f1_valid_reg;
    item_t              f1_item_reg;
    logic [63:0]        sqx_reg;
    logic [63:0]        sqz_reg;
    logic [43:0]        asq_reg;
    logic               f2_valid_reg;
    item_t              f2_item_reg;
    logic signed [24:0] diff;
    logic [ARENA_W-1:0] allowed;
    logic [31:0]        ax;
    logic [31:0]        az;
    item_t              f1_item_next;
    item_t              f2_item_next;

    // stall the front only while the last stage holds a body the queue cannot take
    assign en     = !(f2_valid_reg && q_full);
    assign full   = !en;
    assign q_push = f2_valid_reg && !q_full;
    assign q_item = f2_item_reg;

    // allowed radius and magnitudes
    always_comb
    begin
        diff    = $signed({3'b000, arena}) - $signed({2'b00, body_radius});
        allowed = (diff < $signed({3'b000, MIN_ALLOWED})) ? MIN_ALLOWED : diff[ARENA_W-1:0];
        ax      = pos_x[31] ? 32'(-pos_x) : 32'(pos_x);
        az      = pos_z[31] ? 32'(-pos_z) : 32'(pos_z);
        f1_item_next         = '0;
        f1_item_next.tag     = body_tag;
        f1_item_next.last    = last_body;
        f1_item_next.hit     = body_active;
        f1_item_next.allowed = allowed;
        f1_item_next.px      = pos_x;
        f1_item_next.py      = pos_y;
        f1_item_next.pz      = pos_z;
        f1_item_next.vx      = vel_x;
        f1_item_next.vy      = vel_y;
        f1_item_next.vz      = vel_z;
    end

    // classify: outside the allowed circle
    always_comb
    begin
        f2_item_next     = f1_item_reg;
        f2_item_next.dsq = sqx_reg + sqz_reg;
        f2_item_next.hit = f1_item_reg.hit && (f2_item_next.dsq > {20'd0, asq_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= push;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // square the distances and the allowed radius
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_item_reg <= f1_item_next;
            sqx_reg     <= 64'(ax) * 64'(ax);
            sqz_reg     <= 64'(az) * 64'(az);
            asq_reg     <= 44'(allowed) * 44'(allowed);
            f2_item_reg <= f2_item_next;
        end
    end

endmodule

// ===== sv/cbc_fifo.sv =====
`timescale 1ns / 1ps
module cbc_fifo #(
    parameter int DEPTH = cbc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbc_pkg::item_t in_item,
    output logic           full,
    input  logic           pop,
    output cbc_pkg::item_t out_item,
    output logic           empty
);
    import cbc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign out_item = mem_reg[rd_ptr_reg];

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== sv/cbc_isqrt.sv =====
`timescale 1ns / 1ps
module cbc_isqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cbc_pkg::item_t in_item,
    output logic           out_valid,
    output cbc_pkg::item_t out_item,
    output logic [31:0]    out_root
);
    import cbc_pkg::*;

    logic        valid_reg [SQRT_STEPS];
    item_t       item_reg  [SQRT_STEPS];
    logic [34:0] rem_reg   [SQRT_STEPS];
    logic [31:0] root_reg  [SQRT_STEPS];

    // one root bit per stage, two radicand bits in
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic        prev_valid;
        item_t       prev_item;
        logic [34:0] prev_rem;
        logic [31:0] prev_root;
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic [34:0] rem_next;
        logic [31:0] root_next;

        if (k == 0)
        begin : g_first
            assign prev_valid = in_valid;
            assign prev_item  = in_item;
            assign prev_rem   = '0;
            assign prev_root  = '0;
        end
        else
        begin : g_rest
            assign prev_valid = valid_reg[k-1];
            assign prev_item  = item_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_root  = root_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {prev_rem[32:0], prev_item.dsq[63-2*k -: 2]};
            trial  = {1'b0, prev_root, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {prev_root[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {prev_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= prev_item;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_item  = item_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];

endmodule

// ===== sv/cbc_back.sv =====
`timescale 1ns / 1ps
module cbc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  cbc_pkg::item_t              q_item,
    output logic                        q_pop,
    input  logic [cbc_pkg::COEF_W-1:0]  rest,
    input  logic [cbc_pkg::COEF_W-1:0]  damp,
    input  logic                        pop,
    output logic                        empty,
    output logic [cbc_pkg::TAG_W-1:0]   out_tag,
    output logic                        clamped,
    output logic signed [31:0]          new_pos_x,
    output logic signed [31:0]          new_pos_y,
    output logic signed [31:0]          new_pos_z,
    output logic signed [31:0]          new_vel_x,
    output logic signed [31:0]          new_vel_y,
    output logic signed [31:0]          new_vel_z,
    output logic                        out_last
);
    import cbc_pkg::*;

    logic               en;
    logic               s_valid;
    item_t              s_item;
    logic [31:0]        s_root;

    logic               d_valid_reg [DIV_STEPS];
    item_t              d_item_reg  [DIV_STEPS];
    logic [31:0]        d_dist_reg  [DIV_STEPS];
    logic [48:0]        d_rx_reg    [DIV_STEPS];
    logic [48:0]        d_rz_reg    [DIV_STEPS];
    logic [16:0]        d_qx_reg    [DIV_STEPS];
    logic [16:0]        d_qz_reg    [DIV_STEPS];

    logic signed [17:0] nx;
    logic signed [17:0] nz;
    logic signed [17:0] rest_s;
    logic signed [17:0] damp_s;
    logic signed [38:0] t_vx;
    logic signed [38:0] t_vz;
    logic signed [38:0] t_px;
    logic signed [38:0] t_pz;
    logic signed [38:0] t_vy;

    logic               m1_valid_reg;
    item_t              m1_item_reg;
    logic signed [17:0] m1_nx_reg;
    logic signed [17:0] m1_nz_reg;
    logic signed [35:0] m1_pvx_reg;
    logic signed [35:0] m1_pvz_reg;
    logic signed [35:0] m1_ppx_reg;
    logic signed [35:0] m1_ppz_reg;
    logic signed [35:0] m1_pvy_reg;

    logic signed [36:0] outward_sum;
    logic               m2_valid_reg;
    item_t              m2_item_reg;
    logic signed [17:0] m2_nx_reg;
    logic signed [17:0] m2_nz_reg;
    logic signed [35:0] m2_out_reg;
    logic signed [35:0] m2_ppx_reg;
    logic signed [35:0] m2_ppz_reg;
    logic signed [35:0] m2_pvy_reg;

    logic signed [38:0] t_nvx;
    logic signed [38:0] t_nvz;
    logic               m3_valid_reg;
    item_t              m3_item_reg;
    logic               m3_push_reg;
    logic signed [35:0] m3_nvx_reg;
    logic signed [35:0] m3_nvz_reg;
    logic signed [35:0] m3_ppx_reg;
    logic signed [35:0] m3_ppz_reg;
    logic signed [35:0] m3_pvy_reg;

    logic signed [35:0] tx;
    logic signed [35:0] tz;
    logic signed [38:0] t_ax;
    logic signed [38:0] t_az;
    logic signed [38:0] t_bx;
    logic signed [38:0] t_bz;
    logic               m4_valid_reg;
    item_t              m4_item_reg;
    logic               m4_push_reg;
    logic signed [35:0] m4_ax_reg;
    logic signed [35:0] m4_az_reg;
    logic signed [35:0] m4_bx_reg;
    logic signed [35:0] m4_bz_reg;
    logic signed [35:0] m4_ppx_reg;
    logic signed [35:0] m4_ppz_reg;
    logic signed [35:0] m4_pvy_reg;

    logic               out_valid_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               clamped_reg;
    logic [31:0]        px_reg;
    logic [31:0]        py_reg;
    logic [31:0]        pz_reg;
    logic [31:0]        vx_reg;
    logic [31:0]        vy_reg;
    logic [31:0]        vz_reg;
    logic               last_reg;
    logic [31:0]        px_next;
    logic [31:0]        pz_next;
    logic [31:0]        vx_next;
    logic [31:0]        vy_next;
    logic [31:0]        vz_next;
    logic signed [36:0] nvx_full;
    logic signed [36:0] nvz_full;

    // the whole back pipeline moves when the result register is free or being taken
    assign en    = !out_valid_reg || pop;
    assign q_pop = en && !q_empty;

    cbc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (!q_empty),
        .in_item   (q_item),
        .out_valid (s_valid),
        .out_item  (s_item),
        .out_root  (s_root)
    );

    // normal components: one quotient bit per stage for x and z
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic        prev_valid;
        item_t       prev_item;
        logic [31:0] prev_dist;
        logic [48:0] prev_rx;
        logic [48:0] prev_rz;
        logic [16:0] prev_qx;
        logic [16:0] prev_qz;
        logic [48:0] dsh;
        logic        gx;
        logic        gz;

        if (j == 0)
        begin : g_first
            logic [31:0] ax;
            logic [31:0] az;
            assign ax         = s_item.px[31] ? 32'(-s_item.px) : 32'(s_item.px);
            assign az         = s_item.pz[31] ? 32'(-s_item.pz) : 32'(s_item.pz);
            assign prev_valid = s_valid;
            assign prev_item  = s_item;
            assign prev_dist  = s_root;
            assign prev_rx    = {1'b0, ax, 16'd0} + {18'd0, s_root[31:1]};
            assign prev_rz    = {1'b0, az, 16'd0} + {18'd0, s_root[31:1]};
            assign prev_qx    = '0;
            assign prev_qz    = '0;
        end
        else
        begin : g_rest
            assign prev_valid = d_valid_reg[j-1];
            assign prev_item  = d_item_reg[j-1];
            assign prev_dist  = d_dist_reg[j-1];
            assign prev_rx    = d_rx_reg[j-1];
            assign prev_rz    = d_rz_reg[j-1];
            assign prev_qx    = d_qx_reg[j-1];
            assign prev_qz    = d_qz_reg[j-1];
        end

        assign dsh = 49'(prev_dist) << (DIV_STEPS - 1 - j);
        assign gx  = (prev_rx >= dsh);
        assign gz  = (prev_rz >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_valid_reg[j] <= 1'b0;
            else if (en)
                d_valid_reg[j] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_item_reg[j] <= prev_item;
                d_dist_reg[j] <= prev_dist;
                d_rx_reg[j]   <= gx ? prev_rx - dsh : prev_rx;
                d_rz_reg[j]   <= gz ? prev_rz - dsh : prev_rz;
                d_qx_reg[j]   <= {prev_qx[15:0], gx};
                d_qz_reg[j]   <= {prev_qz[15:0], gz};
            end
        end
    end

    // first products: outward parts, corrected position, damped y velocity
    always_comb
    begin
        nx     = d_item_reg[DIV_STEPS-1].px[31] ? -$signed({1'b0, d_qx_reg[DIV_STEPS-1]})
                                                 : $signed({1'b0, d_qx_reg[DIV_STEPS-1]});
        nz     = d_item_reg[DIV_STEPS-1].pz[31] ? -$signed({1'b0, d_qz_reg[DIV_STEPS-1]})
                                                 : $signed({1'b0, d_qz_reg[DIV_STEPS-1]});
        rest_s = $signed({1'b0, rest});
        damp_s = $signed({1'b0, damp});
        t_vx   = mul_q16(36'(d_item_reg[DIV_STEPS-1].vx), nx);
        t_vz   = mul_q16(36'(d_item_reg[DIV_STEPS-1].vz), nz);
        t_px   = mul_q16($signed({14'd0, d_item_reg[DIV_STEPS-1].allowed}), nx);
        t_pz   = mul_q16($signed({14'd0, d_item_reg[DIV_STEPS-1].allowed}), nz);
        t_vy   = mul_q16(36'(d_item_reg[DIV_STEPS-1].vy), damp_s);
    end

    // normal speed, then the normal velocity
    assign outward_sum = 37'(m1_pvx_reg) + 37'(m1_pvz_reg);
    assign t_nvx       = mul_q16(m2_out_reg, m2_nx_reg);
    assign t_nvz       = mul_q16(m2_out_reg, m2_nz_reg);

    // tangent damping and normal restitution
    always_comb
    begin
        tx   = 36'(m3_item_reg.vx) - m3_nvx_reg;
        tz   = 36'(m3_item_reg.vz) - m3_nvz_reg;
        t_ax = mul_q16(tx, damp_s);
        t_az = mul_q16(tz, damp_s);
        t_bx = mul_q16(m3_nvx_reg, rest_s);
        t_bz = mul_q16(m3_nvz_reg, rest_s);
    end

    // select the result fields
    always_comb
    begin
        nvx_full = 37'(m4_ax_reg) - 37'(m4_bx_reg);
        nvz_full = 37'(m4_az_reg) - 37'(m4_bz_reg);
        px_next  = m4_item_reg.px;
        pz_next  = m4_item_reg.pz;
        vx_next  = m4_item_reg.vx;
        vy_next  = m4_item_reg.vy;
        vz_next  = m4_item_reg.vz;
        if (m4_item_reg.hit)
        begin
            px_next = sat32(40'(m4_ppx_reg));
            pz_next = sat32(40'(m4_ppz_reg));
            if (m4_push_reg)
            begin
                vx_next = sat32(40'(nvx_full));
                vy_next = sat32(40'(m4_pvy_reg));
                vz_next = sat32(40'(nvz_full));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            m4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg  <= d_valid_reg[DIV_STEPS-1];
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            m4_valid_reg  <= m3_valid_reg;
            out_valid_reg <= m4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_item_reg <= d_item_reg[DIV_STEPS-1];
            m1_nx_reg   <= nx;
            m1_nz_reg   <= nz;
            m1_pvx_reg  <= t_vx[35:0];
            m1_pvz_reg  <= t_vz[35:0];
            m1_ppx_reg  <= t_px[35:0];
            m1_ppz_reg  <= t_pz[35:0];
            m1_pvy_reg  <= t_vy[35:0];

            m2_item_reg <= m1_item_reg;
            m2_nx_reg   <= m1_nx_reg;
            m2_nz_reg   <= m1_nz_reg;
            m2_out_reg  <= outward_sum[35:0];
            m2_ppx_reg  <= m1_ppx_reg;
            m2_ppz_reg  <= m1_ppz_reg;
            m2_pvy_reg  <= m1_pvy_reg;

            m3_item_reg <= m2_item_reg;
            m3_push_reg <= (m2_out_reg > 36'sd0);
            m3_nvx_reg  <= t_nvx[35:0];
            m3_nvz_reg  <= t_nvz[35:0];
            m3_ppx_reg  <= m2_ppx_reg;
            m3_ppz_reg  <= m2_ppz_reg;
            m3_pvy_reg  <= m2_pvy_reg;

            m4_item_reg <= m3_item_reg;
            m4_push_reg <= m3_push_reg;
            m4_ax_reg   <= t_ax[35:0];
            m4_az_reg   <= t_az[35:0];
            m4_bx_reg   <= t_bx[35:0];
            m4_bz_reg   <= t_bz[35:0];
            m4_ppx_reg  <= m3_ppx_reg;
            m4_ppz_reg  <= m3_ppz_reg;
            m4_pvy_reg  <= m3_pvy_reg;

            tag_reg     <= m4_item_reg.tag;
            clamped_reg <= m4_item_reg.hit;
            px_reg      <= px_next;
            py_reg      <= m4_item_reg.py;
            pz_reg      <= pz_next;
            vx_reg      <= vx_next;
            vy_reg      <= vy_next;
            vz_reg      <= vz_next;
            last_reg    <= m4_item_reg.last;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_tag   = tag_reg;
    assign clamped   = clamped_reg;
    assign new_pos_x = px_reg;
    assign new_pos_y = py_reg;
    assign new_pos_z = pz_reg;
    assign new_vel_x = vx_reg;
    assign new_vel_y = vy_reg;
    assign new_vel_z = vz_reg;
    assign out_last  = last_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import cbc_pkg::*;

    localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_BODIES = 350;
    localparam int NUM_PHASES = 5;
    localparam int NUM_DIRECTED = 13;

    typedef struct {
        logic [TAG_W-1:0]    tag;
        logic                active;
        logic [RADIUS_W-1:0] radius;
        logic signed [31:0]  px, py, pz, vx, vy, vz;
        logic                last;
    } body_t;

    typedef struct {
        logic [TAG_W-1:0]   tag;
        logic               hit;
        logic signed [31:0] px, py, pz, vx, vy, vz;
        logic               last;
    } bounce_t;

    logic clk, rst_n;
    logic push, full, empty, pop;
    logic [TAG_W-1:0] body_tag, out_tag;
    logic body_active, last_body, clamped, out_last;
    logic [RADIUS_W-1:0] body_radius;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
    logic cfg_valid, cfg_ready;
    logic [ADDR_W-1:0] cfg_addr;
    logic [ARENA_W-1:0] cfg_data;

    circular_boundary_collision dut (.*);

    // predictor copy of the registers
    longint arena_q, rest_q, damp_q;

    body_t   sent_bodies[$];
    bit      sent_typed[$];
    bounce_t sent_results[$];
    bounce_t expected_bounces[$];

    int errors, cycles, accepted, popped, hits;
    bit hold_req;

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint div_near(longint num, longint den);
        longint unsigned q;
        q = (mag(num) + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint mul_fix(longint a, longint b);
        longint unsigned q;
        q = (mag(a) * mag(b) + 64'd32768) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // resolve one body against the arena wall
    function automatic bounce_t resolve_body(body_t b);
        bounce_t r;
        longint px, pz, vx, vy, vz, npx, npz, nvx, nvy, nvz;
        longint allowed, root_len, nx, nz, outward, nvel_x, nvel_z;
        longint unsigned dsq, asq;
        px = b.px; pz = b.pz; vx = b.vx; vy = b.vy; vz = b.vz;
        npx = px; npz = pz; nvx = vx; nvy = vy; nvz = vz;
        r.hit = 0;
        if (b.active)
        begin
            allowed = arena_q - longint'(b.radius);
            if (allowed < 655)
                allowed = 655;
            dsq = mag(px) * mag(px) + mag(pz) * mag(pz);
            asq = allowed * allowed;
            if (dsq > asq)
            begin
                root_len = root64(dsq);
                nx = div_near(px * 65536, root_len);
                nz = div_near(pz * 65536, root_len);
                outward = mul_fix(vx, nx) + mul_fix(vz, nz);
                r.hit = 1;
                npx = mul_fix(nx, allowed);
                npz = mul_fix(nz, allowed);
                if (outward > 0)
                begin
                    nvel_x = mul_fix(nx, outward);
                    nvel_z = mul_fix(nz, outward);
                    nvx = mul_fix(vx - nvel_x, damp_q) - mul_fix(nvel_x, rest_q);
                    nvz = mul_fix(vz - nvel_z, damp_q) - mul_fix(nvel_z, rest_q);
                    nvy = mul_fix(vy, damp_q);
                end
            end
        end
        r.tag = b.tag; r.last = b.last;
        r.px = clip32(npx); r.py = b.py; r.pz = clip32(npz);
        r.vx = clip32(nvx); r.vy = clip32(nvy); r.vz = clip32(nvz);
        return r;
    endfunction

    function automatic body_t mk(logic [15:0] tag, logic act, logic [22:0] rad,
                                 logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                 logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                 logic last);
        body_t b;
        b.tag = tag; b.active = act; b.radius = rad;
        b.px = px; b.py = py; b.pz = pz; b.vx = vx; b.vy = vy; b.vz = vz;
        b.last = last;
        return b;
    endfunction

    function automatic bounce_t untouched(body_t b);
        bounce_t r;
        r.tag = b.tag; r.hit = 0; r.last = b.last;
        r.px = b.px; r.py = b.py; r.pz = b.pz;
        r.vx = b.vx; r.vy = b.vy; r.vz = b.vz;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * arena_q)) - arena_q);
            2: return 32'($signed($urandom_range(0, 6 * arena_q)) - 3 * arena_q);
            default: return 32'($signed($urandom_range(0, 1000)) - 500);
        endcase
    endfunction

    function automatic logic [31:0] rand_speed();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic body_t rand_body();
        body_t b;
        b = mk(TAG_W'($urandom), ($urandom_range(0, 7) != 0),
               ($urandom_range(0, 3) == 0) ? RADIUS_W'($urandom_range(0, 4194304))
                                           : RADIUS_W'($urandom_range(0, 196608)),
               rand_coord(), $urandom, rand_coord(),
               rand_speed(), rand_speed(), rand_speed(), 1'($urandom_range(0, 1)));
        return b;
    endfunction

    task automatic compare(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            errors++;
            $display("%0t: mismatch %s expected %h actual %h", $time, name, e, a);
        end
    endtask

    // clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // watch both handshakes, track config, check results
    always @(posedge clk)
    begin
        bounce_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_addr == REG_ARENA)
                arena_q = (cfg_data < ARENA_MIN) ? longint'(ARENA_MIN) :
                          (cfg_data > ARENA_MAX) ? longint'(ARENA_MAX) : longint'(cfg_data);
            else if (cfg_addr == REG_REST)
                rest_q = (cfg_data[16:0] > UNIT_Q16) ? longint'(UNIT_Q16)
                                                     : longint'(cfg_data[16:0]);
            else if (cfg_addr == REG_DAMP)
                damp_q = (cfg_data[16:0] > UNIT_Q16) ? longint'(UNIT_Q16)
                                                     : longint'(cfg_data[16:0]);
        end
        if (rst_n && push && !full)
        begin
            if (sent_bodies.size() == 0)
            begin
                errors++;
                $display("%0t: request accepted with nothing offered", $time);
            end
            else
            begin
                e = resolve_body(sent_bodies.pop_front());
                if (sent_typed.pop_front())
                    e = sent_results.pop_front();
                expected_bounces.push_back(e);
                accepted++;
            end
        end
        if (rst_n && pop && !empty)
        begin
            popped++;
            if (expected_bounces.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result tag %h", $time, out_tag);
            end
            else
            begin
                e = expected_bounces.pop_front();
                hits += int'(e.hit);
                compare("out_tag", 32'(e.tag), 32'(out_tag));
                compare("clamped", 32'(e.hit), 32'(clamped));
                compare("new_pos_x", e.px, new_pos_x);
                compare("new_pos_y", e.py, new_pos_y);
                compare("new_pos_z", e.pz, new_pos_z);
                compare("new_vel_x", e.vx, new_vel_x);
                compare("new_vel_y", e.vy, new_vel_y);
                compare("new_vel_z", e.vz, new_vel_z);
                compare("out_last", 32'(e.last), 32'(out_last));
            end
        end
    end

    // receiver: stall pattern changes between modes, one long hold-off
    initial
    begin
        int mode, count, hold_cnt;
        bit held;
        pop <= 0;
        mode = 0; count = 0; held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                pop <= 0;
                for (hold_cnt = 0; hold_cnt < 400; hold_cnt++)
                    @(posedge clk);
            end
            count++;
            if (count % 300 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: pop <= 1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((count / 7) % 2 == 0);
            endcase
        end
    end

    int burst_left;

    // offer one body and hold it until accepted
    task automatic send_body(body_t b, bit typed, bounce_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        sent_bodies.push_back(b);
        sent_typed.push_back(typed);
        if (typed)
            sent_results.push_back(r);
        push <= 1;
        body_tag <= b.tag; body_active <= b.active; body_radius <= b.radius;
        pos_x <= b.px; pos_y <= b.py; pos_z <= b.pz;
        vel_x <= b.vx; vel_y <= b.vy; vel_z <= b.vz; last_body <= b.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [ARENA_W-1:0] data);
        cfg_valid <= 1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        push <= 0;
        while (expected_bounces.size() != 0 || sent_bodies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    body_t   dir_rows[NUM_DIRECTED];
    bit      dir_typed[NUM_DIRECTED];
    bounce_t dir_exp[NUM_DIRECTED];

    // stimulus
    initial
    begin
        bounce_t r, none;
        int i, ph;
        arena_q = longint'(ARENA_RST); rest_q = longint'(REST_RST);
        damp_q = longint'(DAMP_RST);
        errors = 0; cycles = 0; accepted = 0; popped = 0; hits = 0;
        burst_left = 0; hold_req = 0;
        none = '{default: '0};
        rst_n <= 0; push <= 0; cfg_valid <= 0; cfg_addr <= REG_ARENA; cfg_data <= '0;
        body_tag <= '0; body_active <= 0; body_radius <= '0; last_body <= 0;
        pos_x <= '0; pos_y <= '0; pos_z <= '0; vel_x <= '0; vel_y <= '0; vel_z <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed rows, default registers
        dir_rows[0] = mk(16'hFFFF, 0, 23'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        dir_rows[1] = mk(16'h0000, 1, 23'd0, 0, 32'd12345, 0, 32'd65536, 0, 0, 0);
        dir_rows[2] = mk(16'h0002, 1, 23'd0, 32'd655360, 0, 0, 32'd65536, 0, 0, 0);
        dir_rows[3] = mk(16'h0003, 1, 23'd0, 32'd1310720, 32'd7, 0, 0, 0, 0, 0);
        dir_rows[4] = mk(16'h0004, 1, 23'd0, 32'd1310720, 0, 0, 32'd65536, 0, 0, 1);
        dir_rows[5] = mk(16'h0005, 1, 23'd4194304, 32'd65536, 0, 32'd65536,
                         32'd65536, 32'd65536, 32'd65536, 0);
        dir_rows[6] = mk(16'h0006, 1, 23'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        dir_rows[7] = mk(16'h0007, 1, 23'd0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        dir_rows[8] = mk(16'h0008, 1, 23'd0, -32'sd1310720, 0, 32'd1310720,
                         32'd100000, 32'd5000, -32'sd100000, 0);
        dir_rows[9] = mk(16'h0009, 1, 23'd65536, 0, 0, -32'sd983040,
                         32'd4000, -32'sd9000, -32'sd70000, 1);
        dir_rows[10] = mk(16'h000A, 1, 23'd655360, 32'd10000, 0, -32'sd10000,
                          -32'sd50, 0, 32'd50, 0);
        dir_rows[11] = mk(16'h000B, 1, 23'd0, 32'd1310720, 0, 32'd1, -32'sd65536, 0, 0, 0);
        dir_rows[12] = mk(16'h000C, 1, 23'd100000, 32'd700000, 32'hDEAD_BEEF, 32'd300000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            dir_typed[i] = (i < 5);
            dir_exp[i] = untouched(dir_rows[i]);
        end
        // wall hit, no outward speed: position snapped, velocity kept
        dir_exp[3].hit = 1; dir_exp[3].px = 655360;
        // wall hit moving out along x: bounce by restitution
        dir_exp[4].hit = 1; dir_exp[4].px = 655360; dir_exp[4].vx = -32'sd47186;
        for (i = 0; i < NUM_DIRECTED; i++)
            send_body(dir_rows[i], dir_typed[i], dir_exp[i]);

        // random phases, registers changed between them
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                case (ph)
                    1:
                    begin
                        write_reg(REG_ARENA, ARENA_MIN);
                        write_reg(REG_REST, '0);
                        write_reg(REG_DAMP, ARENA_W'(UNIT_Q16));
                    end
                    2:
                    begin
                        write_reg(REG_ARENA, ARENA_MAX);
                        write_reg(REG_REST, ARENA_W'(UNIT_Q16));
                        write_reg(REG_DAMP, '0);
                    end
                    3:
                    begin
                        write_reg(REG_ARENA, 22'h3F_FFFF);
                        write_reg(REG_REST, 22'h3F_FFFF);
                        write_reg(REG_DAMP, 22'h3F_FFFF);
                        write_reg(REG_UNUSED, ARENA_W'($urandom));
                    end
                    default:
                    begin
                        write_reg(REG_ARENA, '0);
                        write_reg(REG_ARENA, ARENA_W'($urandom_range(ARENA_MIN, ARENA_MAX)));
                        write_reg(REG_REST, ARENA_W'($urandom_range(0, 65536)));
                        write_reg(REG_DAMP, ARENA_W'($urandom_range(0, 65536)));
                    end
                endcase
            end
            if (ph == 1)
                hold_req = 1;
            for (i = 0; i < PHASE_BODIES; i++)
                send_body(rand_body(), 0, none);
        end

        wait_idle();
        $display("%0d bodies accepted, %0d results checked, %0d wall contacts",
                 accepted, popped, hits);
        $display("%0d register settings including extremes and out-of-range writes",
                 NUM_PHASES);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
